[sv/wear_leveled_record_ring_top_assert.svh]
// assertion macros used by the record ring sequencer (wlrr_ctrl)
// expects clk and arst_n in the scope of use
`ifndef WEAR_LEVELED_RECORD_RING_TOP_ASSERT_SVH
`define WEAR_LEVELED_RECORD_RING_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define WLRR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define WLRR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define WLRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/wlrr_pkg.sv]
// shared types and constants of the wear-leveled record ring
// no dependencies
package wlrr_pkg;

	localparam int DATA_W = 64;

	localparam logic [1:0] CFG_REGION_BASE  = 2'd0;
	localparam logic [1:0] CFG_REGION_BYTES = 2'd1;
	localparam logic [1:0] CFG_RECORD_BYTES = 2'd2;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [7:0] MARK_ERASED = 8'hff;
	localparam logic [7:0] MARK_WRAP   = 8'hfe;

	localparam logic [9:0]  RST_REGION_BASE  = 10'd0;
	localparam logic [10:0] RST_REGION_BYTES = 11'd1024;
	localparam logic [3:0]  RST_RECORD_BYTES = 4'd8;

	typedef struct packed {
		logic [9:0]  region_base;
		logic [10:0] region_bytes;
		logic [3:0]  record_bytes;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_data;
		logic [9:0]        slot_offset;
	} result_t;

endpackage

[sv/wear_leveled_record_ring_top.sv]
// a command runs as: fold region_base into the store (minus STORE_BYTES per step), scan the
// marks (at most region_bytes/(record_bytes+1) + 2 read), move the n record bytes and, for
// a write, commit the mark; one item at a time.
// the single store port (one byte per cycle) sets the rate of scan and transfer.
// after reset the store is swept to 0xff; no beat is taken meanwhile, config writes are;
// registers reset to base 0, 1024 bytes, 8-byte records
module wear_leveled_record_ring_top #(
	parameter int STORE_BYTES      = 1024,
	parameter int MAX_RECORD_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // write_data[63:0], byte_count[67:64], zero pad
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // read_data[63:0], slot_offset[73:64], zero pad
	output logic        m_tuser,  // found
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int AW = $clog2(STORE_BYTES);

	wlrr_pkg::cfg_t    cfg_q;
	wlrr_pkg::result_t res;
	wlrr_pkg::result_t out_q;
	logic              out_vld_q;
	logic              ready;
	logic              res_valid;
	logic              res_take;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_base  <= wlrr_pkg::RST_REGION_BASE;
			cfg_q.region_bytes <= wlrr_pkg::RST_REGION_BYTES;
			cfg_q.record_bytes <= wlrr_pkg::RST_RECORD_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				wlrr_pkg::CFG_REGION_BASE:  cfg_q.region_base  <= cfg_data[9:0];
				wlrr_pkg::CFG_REGION_BYTES: cfg_q.region_bytes <= cfg_data;
				wlrr_pkg::CFG_RECORD_BYTES: cfg_q.record_bytes <= cfg_data[3:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign res_take = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	wlrr_ctrl #(
		.STORE_BYTES      (STORE_BYTES),
		.MAX_RECORD_BYTES (MAX_RECORD_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid),
		.cmd       (s_tuser),
		.wdata     (s_tdata[63:0]),
		.count     (s_tdata[67:64]),
		.cfg       (cfg_q),
		.ready     (ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	wlrr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign s_tready = ready;
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.found;
	assign m_tdata  = {6'd0, out_q.slot_offset, out_q.read_data};

endmodule

[sv/wlrr_ram.sv]
// generic single-port synchronous ram, registered read
// no dependencies
module wlrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[sv/wlrr_ctrl.sv]
// sequencer of the record ring: store clear, mark scan, record transfer, mark commit
// depends on wlrr_pkg and the assertion macro header
`include "wear_leveled_record_ring_top_assert.svh"

module wlrr_ctrl #(
	parameter int STORE_BYTES      = 1024,
	parameter int MAX_RECORD_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           cmd,
	input  logic [wlrr_pkg::DATA_W-1:0]    wdata,
	input  logic [3:0]                     count,
	input  wlrr_pkg::cfg_t                 cfg,
	output logic                           ready,
	output logic                           res_valid,
	input  logic                           res_take,
	output wlrr_pkg::result_t              res,
	output logic                           ram_we,
	output logic [$clog2(STORE_BYTES)-1:0] ram_addr,
	output logic [7:0]                     ram_wdata,
	input  logic [7:0]                     ram_rdata
);

	localparam int AW = $clog2(STORE_BYTES);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_PREP  = 8'b0000_0100,
		ST_SCAN  = 8'b0000_1000,
		ST_CALC  = 8'b0001_0000,
		ST_XFER  = 8'b0010_0000,
		ST_MARK  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [4:0] d);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(d);
		if (s >= (AW+1)'(STORE_BYTES)) begin
			s = s - (AW+1)'(STORE_BYTES);
		end
		return s[AW-1:0];
	endfunction

	state_t                    state_q;
	logic [AW-1:0]             clr_addr_q;
	logic                      cmd_q;
	logic [wlrr_pkg::DATA_W-1:0] wdata_q;
	logic [3:0]                n_q;
	logic [9:0]                wbase_q;
	logic [AW-1:0]             base_addr_q;

	logic [11:0]               off_q;
	logic [AW-1:0]             iaddr_q;
	logic                      first_q;
	logic                      vld_s1;
	logic                      visit_s1;
	logic [10:0]               off_s1;
	logic [AW-1:0]             addr_s1;
	logic [7:0]                head_q;
	logic                      any_q;
	logic [10:0]               last_q;
	logic [AW-1:0]             last_addr_q;

	logic [3:0]                k_q;
	logic [AW-1:0]             byte_addr_q;
	logic                      rvld_s1;
	logic [2:0]                rk_s1;
	logic [wlrr_pkg::DATA_W-1:0] acc_q;
	logic [7:0]                mark_q;
	logic [AW-1:0]             mark_addr_q;
	logic                      found_q;
	logic [9:0]                slot_q;

	logic [4:0]                stride;
	logic [3:0]                n_min;
	logic [3:0]                n_lim;
	logic                      first_s1;
	logic [7:0]                head_now;
	logic                      scan_stop;
	logic                      scan_more;
	logic                      scan_issue;
	logic                      xfer_issue;
	logic [11:0]               nxt_off;
	logic                      nxt_wrap;
	logic [AW-1:0]             nxt_addr;

	assign stride     = 5'(cfg.record_bytes) + 5'd1;
	assign n_min      = (cfg.record_bytes < count) ? cfg.record_bytes : count;
	assign n_lim      = (n_min > 4'(MAX_RECORD_BYTES)) ? 4'(MAX_RECORD_BYTES) : n_min;

	assign first_s1   = vld_s1 && (off_s1 == 11'd0);
	assign head_now   = first_s1 ? ram_rdata : head_q;
	assign scan_stop  = vld_s1 && (ram_rdata != head_now);
	assign scan_more  = first_q || (off_q < 12'(cfg.region_bytes));
	assign scan_issue = !scan_stop && scan_more;
	assign xfer_issue = k_q < n_q;

	always_comb begin
		nxt_off = any_q ? (12'(last_q) + 12'(stride)) : 12'd0;
		if (nxt_off >= 12'(cfg.region_bytes)) begin
			nxt_off = 12'd0;
		end
		nxt_wrap = (nxt_off == 12'd0);
		nxt_addr = nxt_wrap ? base_addr_q : addr_add(last_addr_q, stride);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = iaddr_q;
		ram_wdata = wlrr_pkg::MARK_ERASED;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			ST_XFER: begin
				ram_addr = byte_addr_q;
				if (cmd_q == wlrr_pkg::CMD_WRITE) begin
					ram_we    = xfer_issue;
					ram_wdata = wdata_q[8*k_q[2:0] +: 8];
				end
			end
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_addr  = mark_addr_q;
				ram_wdata = mark_q;
			end
			default: begin
				ram_addr = iaddr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			vld_s1     <= 1'b0;
			rvld_s1    <= 1'b0;
			first_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (32'(wbase_q) < STORE_BYTES) begin
						state_q <= ST_SCAN;
						first_q <= 1'b1;
						vld_s1  <= 1'b0;
					end
				end
				ST_SCAN: begin
					vld_s1 <= scan_issue;
					if (scan_issue) begin
						first_q <= 1'b0;
					end
					if (scan_stop || (!vld_s1 && !scan_more)) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					rvld_s1 <= 1'b0;
					if ((cmd_q == wlrr_pkg::CMD_READ) && !any_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_XFER;
					end
				end
				ST_XFER: begin
					if (cmd_q == wlrr_pkg::CMD_READ) begin
						rvld_s1 <= xfer_issue;
						if (!xfer_issue && !rvld_s1) begin
							state_q <= ST_DONE;
						end
					end else if (!xfer_issue) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd;
				wdata_q <= wdata;
				n_q     <= n_lim;
				wbase_q <= cfg.region_base;
			end
			ST_PREP: begin
				if (32'(wbase_q) >= STORE_BYTES) begin
					wbase_q <= wbase_q - 10'(STORE_BYTES);
				end else begin
					base_addr_q <= AW'(wbase_q);
					iaddr_q     <= AW'(wbase_q);
					off_q       <= 12'd0;
					any_q       <= 1'b0;
					last_q      <= 11'd0;
					last_addr_q <= AW'(wbase_q);
				end
			end
			ST_SCAN: begin
				visit_s1 <= off_q < 12'(cfg.region_bytes);
				off_s1   <= off_q[10:0];
				addr_s1  <= iaddr_q;
				if (scan_issue) begin
					off_q   <= off_q + 12'(stride);
					iaddr_q <= addr_add(iaddr_q, stride);
				end
				if (vld_s1) begin
					head_q <= head_now;
					if (visit_s1) begin
						if (ram_rdata != wlrr_pkg::MARK_ERASED) begin
							any_q <= 1'b1;
						end
						if (!scan_stop) begin
							last_q      <= off_s1;
							last_addr_q <= addr_s1;
						end
					end
				end
			end
			ST_CALC: begin
				k_q   <= 4'd0;
				acc_q <= '0;
				if (cmd_q == wlrr_pkg::CMD_READ) begin
					found_q     <= any_q;
					slot_q      <= any_q ? last_q[9:0] : 10'd0;
					byte_addr_q <= addr_add(last_addr_q, 5'd1);
				end else begin
					found_q     <= 1'b1;
					slot_q      <= nxt_off[9:0];
					mark_addr_q <= nxt_addr;
					byte_addr_q <= addr_add(nxt_addr, 5'd1);
					if (nxt_wrap) begin
						mark_q <= (head_q != 8'd0) ? 8'd0 : wlrr_pkg::MARK_WRAP;
					end else begin
						mark_q <= head_q;
					end
				end
			end
			ST_XFER: begin
				rk_s1 <= k_q[2:0];
				if (xfer_issue) begin
					k_q         <= k_q + 4'd1;
					byte_addr_q <= addr_add(byte_addr_q, 5'd1);
				end
				if ((cmd_q == wlrr_pkg::CMD_READ) && rvld_s1) begin
					acc_q[8*rk_s1 +: 8] <= ram_rdata;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign ready           = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_DONE);
	assign res.found       = found_q;
	assign res.read_data   = acc_q;
	assign res.slot_offset = slot_q;

	`WLRR_ASSERT_IMPL(a_scan_no_write, state_q == ST_SCAN, !ram_we, "store written during scan")
	`WLRR_ASSERT_IMPL(a_xfer_bound, state_q == ST_XFER, k_q <= n_q, "byte count overrun")
	`WLRR_ASSERT_NEXT(a_done_idle, (state_q == ST_DONE) && res_take, state_q == ST_IDLE, "result not retired")
	`WLRR_ASSERT_ALWAYS(a_addr_range, !ram_we || (32'(ram_addr) < STORE_BYTES), "store address out of range")

endmodule
